### sv/hda_pkg.sv
// hda_pkg: shared constants for the hankel diagonal averager
// defaults for the top-level parameters, configuration register indexes and field widths
// no dependencies
package hda_pkg;

  // default sizing of the top level
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_COLS    = 256;
  localparam int DEF_SAMPLE_BITS = 24;

  // configuration port
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 9;

  // widths of the configuration registers
  localparam int ROW_COUNT_BITS    = 7;
  localparam int COLUMN_COUNT_BITS = 9;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = CFG_INDEX_BITS'(1);

endpackage

### sv/hankel_diagonal_averager_unit.sv
// hankel_diagonal_averager_unit: anti-diagonal averaging (hankelization) of a streamed matrix
// uses hda_pkg for parameter defaults and register indexes
// holds the per-diagonal sum memory and the divide pipeline
//
// The block takes a row_count by column_count matrix, one element per request in
// column-major order (row runs fastest), and returns the mean of every anti-diagonal
// d = row + column in order of d, truncated toward zero. A mean leaves on the element
// that closes its diagonal: the top element of each column but the last and every
// element of the last column; m_tlast marks the final mean of the matrix. Running
// sums live in one memory with a registered read: the read is issued as the
// element is taken, the sum is formed in stage 1 and written back as it advances, and a
// read that meets the write of the element just before it takes the forwarded sum.
// The block accepts one element per clock whenever the output side keeps up; a mean
// passes from the read-modify-write of the sum memory in stage 1 through the
// closed-sum, reciprocal, product and check stages of the divide to the output
// register. The sum memory needs no clearing after reset, as every diagonal is
// overwritten by its first element.
// Writing either count drops any matrix in progress; write it only while idle.
module hankel_diagonal_averager_unit
  import hda_pkg::*;
#(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  // derived port widths
  parameter int DIAG_BITS     = ((MAX_ROWS + MAX_COLS - 1) > 1) ?
                                $clog2(MAX_ROWS + MAX_COLS - 1) : 1,
  parameter int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8,
  parameter int OUT_DATA_BITS = ((SAMPLE_BITS + DIAG_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  // element requests
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_DATA_BITS-1:0]   s_tdata,   // element_value, zero padded
  // mean requests
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_DATA_BITS-1:0]  m_tdata,   // diagonal_mean, diagonal_index, zero padded
  output logic                      m_tlast,   // matrix_done
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // sizing
  localparam int DIAG_DEPTH   = MAX_ROWS + MAX_COLS - 1;
  localparam int ROW_IDX_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_IDX_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_CNT_BITS = $clog2(MAX_ROWS + 1);
  localparam int COL_CNT_BITS = $clog2(MAX_COLS + 1);
  localparam int LEN_MAX      = (MAX_ROWS < MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int LEN_BITS     = $clog2(LEN_MAX + 1);
  localparam int LEN_DEPTH    = 2 ** LEN_BITS;
  localparam int SUM_BITS     = SAMPLE_BITS + $clog2(LEN_MAX);
  localparam int LW           = DIAG_BITS + 1;
  // reciprocal divide
  localparam int RECIP_SHIFT  = SUM_BITS;
  localparam int RECIP_BITS   = SUM_BITS + 1;
  localparam int PROD_BITS    = SUM_BITS + RECIP_BITS;
  localparam int M_BITS       = SAMPLE_BITS + 1 + LEN_BITS;
  localparam int CMP_BITS     = (SUM_BITS > M_BITS) ? SUM_BITS : M_BITS;

  // configuration and position registers
  logic [ROW_CNT_BITS-1:0] nr;
  logic [COL_CNT_BITS-1:0] nc;
  logic [ROW_IDX_BITS-1:0] row_pos;
  logic [COL_IDX_BITS-1:0] col_pos;
  logic                    cfg_we;
  logic [31:0]             cfg_rows;
  logic [31:0]             cfg_cols;

  // accept side
  logic                    s_accept;
  logic                    r_top;
  logic                    r_bottom;
  logic                    c_first;
  logic                    c_end;
  logic [DIAG_BITS-1:0]    d_in;

  // sum memory
  logic signed [SUM_BITS-1:0] sum_mem [DIAG_DEPTH];
  logic signed [SUM_BITS-1:0] wr_sum;

  // stage 1: memory data, sum formed and written back
  logic                          valid1;
  logic signed [SAMPLE_BITS-1:0] v1;
  logic [DIAG_BITS-1:0]          d1;
  logic                          first1;
  logic                          last1;
  logic                          done1;
  logic                          fwd1;
  logic signed [SUM_BITS-1:0]    rd1;
  logic signed [SUM_BITS-1:0]    base1;
  logic signed [SUM_BITS-1:0]    sum1;
  logic [LW-1:0]                 la;
  logic [LW-1:0]                 lb;
  logic [LW-1:0]                 lc;
  logic [LW-1:0]                 le;
  logic [LW-1:0]                 lmin;
  logic [LEN_BITS-1:0]           len1;
  logic                          adv1;
  logic                          free1;

  // stage 2: closed sum
  logic                       valid2;
  logic signed [SUM_BITS-1:0] sum2;
  logic [DIAG_BITS-1:0]       d2;
  logic                       done2;
  logic [LEN_BITS-1:0]        len2;
  logic                       free2;
  logic [RECIP_BITS-1:0]      recip_tab [LEN_DEPTH];

  // stage 3: magnitude and reciprocal
  logic                  valid3;
  logic [SUM_BITS-1:0]   abs3;
  logic                  neg3;
  logic [RECIP_BITS-1:0] recip3;
  logic [LEN_BITS-1:0]   len3;
  logic [DIAG_BITS-1:0]  d3;
  logic                  done3;
  logic                  free3;

  // stage 4: product
  logic                 valid4;
  logic [PROD_BITS-1:0] prod4;
  logic [SUM_BITS-1:0]  abs4;
  logic                 neg4;
  logic [LEN_BITS-1:0]  len4;
  logic [DIAG_BITS-1:0] d4;
  logic                 done4;
  logic                 free4;
  logic [SAMPLE_BITS-1:0] q0_4;

  // stage 5: estimate and check product
  logic                   valid5;
  logic [SAMPLE_BITS-1:0] q05;
  logic [M_BITS-1:0]      m5;
  logic [SUM_BITS-1:0]    abs5;
  logic                   neg5;
  logic [DIAG_BITS-1:0]   d5;
  logic                   done5;
  logic                   free5;
  logic                   corr5;
  logic [SAMPLE_BITS-1:0] mean5;

  // output register
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] m_mean;
  logic [DIAG_BITS-1:0]   m_index;

  // ---------------------------------------------------------------------------
  // handshakes: each stage moves when the next one is empty or moving
  // ---------------------------------------------------------------------------
  assign out_free = !m_tvalid || m_tready;
  assign free5    = !valid5 || out_free;
  assign free4    = !valid4 || free5;
  assign free3    = !valid3 || free4;
  assign free2    = !valid2 || free3;
  // elements that close no diagonal end in stage 1
  assign adv1     = valid1 && (!last1 || free2);
  assign free1    = !valid1 || !last1 || free2;
  assign s_tready = free1;
  assign s_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // ---------------------------------------------------------------------------
  // configuration: counts are clamped into range as they are written
  // ---------------------------------------------------------------------------
  assign cfg_rows = 32'(cfg_data[ROW_COUNT_BITS-1:0]);
  assign cfg_cols = 32'(cfg_data[COLUMN_COUNT_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      nr <= ROW_CNT_BITS'(1);
      nc <= COL_CNT_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT: begin
          if (cfg_rows == 32'd0) begin
            nr <= ROW_CNT_BITS'(1);
          end else if (cfg_rows > 32'(MAX_ROWS)) begin
            nr <= ROW_CNT_BITS'(MAX_ROWS);
          end else begin
            nr <= ROW_CNT_BITS'(cfg_rows);
          end
        end
        REG_COLUMN_COUNT: begin
          if (cfg_cols == 32'd0) begin
            nc <= COL_CNT_BITS'(1);
          end else if (cfg_cols > 32'(MAX_COLS)) begin
            nc <= COL_CNT_BITS'(MAX_COLS);
          end else begin
            nc <= COL_CNT_BITS'(cfg_cols);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // element position, column-major
  // ---------------------------------------------------------------------------
  assign r_top    = (row_pos == '0);
  assign r_bottom = (ROW_CNT_BITS'(row_pos) == nr - ROW_CNT_BITS'(1));
  assign c_first  = (col_pos == '0);
  assign c_end    = (COL_CNT_BITS'(col_pos) == nc - COL_CNT_BITS'(1));
  assign d_in     = DIAG_BITS'(row_pos) + DIAG_BITS'(col_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (cfg_we) begin
      // a known register write drops the matrix in progress
      if (cfg_index == REG_ROW_COUNT || cfg_index == REG_COLUMN_COUNT) begin
        row_pos <= '0;
        col_pos <= '0;
      end
    end else if (s_accept) begin
      if (r_bottom) begin
        row_pos <= '0;
        col_pos <= c_end ? '0 : col_pos + COL_IDX_BITS'(1);
      end else begin
        row_pos <= row_pos + ROW_IDX_BITS'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sum memory: read as the element is taken, written back from stage 1
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s_accept) begin
      rd1 <= sum_mem[d_in];
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      sum_mem[d1] <= sum1;
      wr_sum      <= sum1;
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (free1) begin
      valid1 <= s_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      v1     <= s_tdata[SAMPLE_BITS-1:0];
      d1     <= d_in;
      first1 <= c_first || r_bottom;
      last1  <= r_top || c_end;
      done1  <= r_bottom && c_end;
      // the element ahead writes this diagonal on the same edge as our read
      fwd1   <= valid1 && (d1 == d_in);
    end
  end

  // first element of a diagonal overwrites, later ones accumulate
  assign base1 = fwd1 ? wr_sum : rd1;
  assign sum1  = first1 ? SUM_BITS'(v1) : base1 + SUM_BITS'(v1);

  // diagonal length: min(d, rows-1, cols-1, rows+cols-2-d) + 1
  always_comb begin
    la   = LW'(d1);
    lb   = LW'(nr) - LW'(1);
    lc   = LW'(nc) - LW'(1);
    le   = LW'(nr) + LW'(nc) - LW'(2) - LW'(d1);
    lmin = la;
    if (lb < lmin) begin
      lmin = lb;
    end
    if (lc < lmin) begin
      lmin = lc;
    end
    if (le < lmin) begin
      lmin = le;
    end
  end
  assign len1 = LEN_BITS'(lmin + LW'(1));

  // ---------------------------------------------------------------------------
  // stage 2
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (free2) begin
      valid2 <= adv1 && last1;
    end
  end

  always_ff @(posedge clk) begin
    if (free2 && adv1 && last1) begin
      sum2  <= sum1;
      d2    <= d1;
      done2 <= done1;
      len2  <= len1;
    end
  end

  // reciprocal table: floor(2^RECIP_SHIFT / len), unused at len zero
  for (genvar g = 0; g < LEN_DEPTH; g++) begin : g_recip
    localparam logic [RECIP_BITS-1:0] RecipVal =
      RECIP_BITS'((64'd1 << RECIP_SHIFT) / ((g == 0) ? 1 : g));
    assign recip_tab[g] = RecipVal;
  end

  // ---------------------------------------------------------------------------
  // stage 3: magnitude and reciprocal
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (free3) begin
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (free3 && valid2) begin
      neg3   <= sum2[SUM_BITS-1];
      abs3   <= sum2[SUM_BITS-1] ? SUM_BITS'(-sum2) : SUM_BITS'(sum2);
      recip3 <= recip_tab[len2];
      len3   <= len2;
      d3     <= d2;
      done3  <= done2;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: magnitude times reciprocal
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
    end else if (free4) begin
      valid4 <= valid3;
    end
  end

  always_ff @(posedge clk) begin
    if (free4 && valid3) begin
      prod4 <= PROD_BITS'(abs3) * PROD_BITS'(recip3);
      abs4  <= abs3;
      neg4  <= neg3;
      len4  <= len3;
      d4    <= d3;
      done4 <= done3;
    end
  end

  // the estimate is the true quotient or one below it
  assign q0_4 = prod4[RECIP_SHIFT +: SAMPLE_BITS];

  // ---------------------------------------------------------------------------
  // stage 5: (estimate + 1) * len decides the correction
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      valid5 <= 1'b0;
    end else if (free5) begin
      valid5 <= valid4;
    end
  end

  always_ff @(posedge clk) begin
    if (free5 && valid4) begin
      q05   <= q0_4;
      m5    <= (M_BITS'(q0_4) + M_BITS'(1)) * M_BITS'(len4);
      abs5  <= abs4;
      neg5  <= neg4;
      d5    <= d4;
      done5 <= done4;
    end
  end

  assign corr5 = (CMP_BITS'(abs5) >= CMP_BITS'(m5));
  // negation folded into the correcting add: -(q+c) = ~q + (1-c)
  assign mean5 = neg5 ? (~q05 + SAMPLE_BITS'(!corr5)) : (q05 + SAMPLE_BITS'(corr5));

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= valid5;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && valid5) begin
      m_mean  <= mean5;
      m_index <= d5;
      m_tlast <= done5;
    end
  end

  assign m_tdata = OUT_DATA_BITS'({m_index, m_mean});

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (ROW_CNT_BITS'(row_pos) < nr) && (COL_CNT_BITS'(col_pos) < nc))
    else $error("element position outside the configured matrix");

  a_done_wraps: assert property (@(posedge clk) disable iff (rst)
    s_accept && r_bottom && c_end |=> (row_pos == '0) && (col_pos == '0))
    else $error("positions did not return to zero after the last element");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_index) < 32'(DIAG_DEPTH)))
    else $error("diagonal index beyond the sum memory");

  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    s_accept && valid1 && (d1 == d_in) |-> adv1)
    else $error("forwarded sum would come from an element that is not written");

endmodule

### bench/hankel_diagonal_averager_unit_tb.sv
// hankel_diagonal_averager_unit_tb: self-checking bench for the anti-diagonal averager
// streams matrices through the block and checks every diagonal mean against its own predictor
// depends on hda_pkg and hankel_diagonal_averager_unit
`timescale 1ns / 1ps

module hankel_diagonal_averager_unit_tb;
  import hda_pkg::*;

  localparam int SAMPLE_BITS   = DEF_SAMPLE_BITS;
  localparam int DIAG_DEPTH    = DEF_MAX_ROWS + DEF_MAX_COLS - 1;
  localparam int DIAG_BITS     = $clog2(DIAG_DEPTH);
  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((SAMPLE_BITS + DIAG_BITS + 7) / 8) * 8;

  // idle time after the last mean so the pipeline empties, leave plenty of margin
  localparam int SETTLE_CYCLES    = 16;
  localparam int RANDOM_ELEMENTS  = 150;
  localparam int REPORT_LIMIT     = 10;

  // register indexes past the end of the list, both must be ignored
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_FIRST = REG_COLUMN_COUNT + 1'b1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LAST  = '1;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] mean;
    logic [DIAG_BITS-1:0]   index;
    logic                   done;
  } diag_mean_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_DATA_BITS-1:0]   s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]  m_tdata;
  logic                      m_tlast;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  hankel_diagonal_averager_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state: one running sum per diagonal, write position, register copies
  longint                       running_sums [DIAG_DEPTH];
  int unsigned                  next_row = 0;
  int unsigned                  next_column = 0;
  logic [ROW_COUNT_BITS-1:0]    rows_setting = ROW_COUNT_BITS'(1);
  logic [COLUMN_COUNT_BITS-1:0] columns_setting = COLUMN_COUNT_BITS'(1);
  diag_mean_t                   pending_means [$];

  int  mismatches = 0;
  int  means_checked = 0;
  int  elements_sent = 0;
  int  random_elements = 0;
  int  register_writes = 0;
  int  stall_left = 0;
  bit  sender_idling = 1'b1;
  bit  receiver_idling = 1'b1;

  function automatic int unsigned active_rows();
    if (rows_setting == 0) return 1;
    if (rows_setting > DEF_MAX_ROWS) return DEF_MAX_ROWS;
    return 32'(rows_setting);
  endfunction

  function automatic int unsigned active_columns();
    if (columns_setting == 0) return 1;
    if (columns_setting > DEF_MAX_COLS) return DEF_MAX_COLS;
    return 32'(columns_setting);
  endfunction

  // a write to a known register restarts the matrix, an unknown index changes nothing
  function automatic void apply_register_write(logic [CFG_INDEX_BITS-1:0] index,
                                               logic [CFG_DATA_BITS-1:0] data);
    if (index == REG_ROW_COUNT) begin
      rows_setting = data[ROW_COUNT_BITS-1:0];
    end else if (index == REG_COLUMN_COUNT) begin
      columns_setting = data[COLUMN_COUNT_BITS-1:0];
    end else begin
      return;
    end
    next_row = 0;
    next_column = 0;
  endfunction

  // accumulate one element and queue the mean if it closes its diagonal
  function automatic void average_element(logic [SAMPLE_BITS-1:0] raw);
    int unsigned nr, nc, r, c, d, span_a, span_b, len;
    logic opens, closes, done;
    longint sample, quotient;
    diag_mean_t result;
    nr = active_rows();
    nc = active_columns();
    r = next_row;
    c = next_column;
    if (r >= nr) r = 0;
    if (c >= nc) c = 0;
    d = r + c;
    if (d >= DIAG_DEPTH) d = DIAG_DEPTH - 1;
    opens  = (c == 0) || (r == nr - 1);
    closes = (r == 0) || (c == nc - 1);
    done   = (r == nr - 1) && (c == nc - 1);
    sample = longint'($signed(raw));
    if (opens) running_sums[d] = sample;
    else running_sums[d] += sample;
    if (closes) begin
      span_a = (d < nr - 1) ? d : nr - 1;
      span_b = (nc - 1 < nr + nc - 2 - d) ? nc - 1 : nr + nc - 2 - d;
      len = ((span_a < span_b) ? span_a : span_b) + 1;
      quotient = running_sums[d] / longint'(len);
      result.mean  = quotient[SAMPLE_BITS-1:0];
      result.index = d[DIAG_BITS-1:0];
      result.done  = done;
      pending_means.push_back(result);
    end
    r++;
    if (r >= nr) begin
      r = 0;
      c++;
      if (c >= nc) c = 0;
    end
    next_row = r;
    next_column = c;
  endfunction

  // output side stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare every mean request with the oldest prediction
  always @(posedge clk) begin
    diag_mean_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_means.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mean request with none predicted: mean %0d index %0d last %0b",
                   $realtime, $signed(m_tdata[SAMPLE_BITS-1:0]),
                   m_tdata[SAMPLE_BITS +: DIAG_BITS], m_tlast);
      end else begin
        want = pending_means.pop_front();
        means_checked++;
        if (m_tdata[SAMPLE_BITS-1:0] !== want.mean ||
            m_tdata[SAMPLE_BITS +: DIAG_BITS] !== want.index || m_tlast !== want.done) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: mean mismatch: expected mean %0d index %0d last %0b, got %0d %0d %0b",
                     $realtime, $signed(want.mean), want.index, want.done,
                     $signed(m_tdata[SAMPLE_BITS-1:0]), m_tdata[SAMPLE_BITS +: DIAG_BITS],
                     m_tlast);
        end
      end
    end
  end

  // all tasks below start and end on a rising edge
  task automatic send_element(input logic [SAMPLE_BITS-1:0] value);
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_BITS'(value);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    average_element(value);
    elements_sent++;
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_means.size() != 0);
  endtask

  // drain all means, then give the pipeline time to empty out non-closing elements
  task automatic settle_idle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] data);
    cfg_index <= index;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register_write(index, data);
    register_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int rows, input int columns);
    settle_idle();
    write_register(REG_ROW_COUNT, CFG_DATA_BITS'(rows));
    write_register(REG_COLUMN_COUNT, CFG_DATA_BITS'(columns));
  endtask

  function automatic logic [SAMPLE_BITS-1:0] random_element();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // random content, with an occasional pause until every mean is back
  task automatic send_random_elements(input int count);
    repeat (count) begin
      if (sender_idling && $urandom_range(0, 39) == 0) hold_until_drained();
      send_element(random_element());
    end
  endtask

  task automatic test_single_element_matrices();
    // reset leaves a 1 by 1 matrix: every element is its own mean and ends the matrix
    send_element(SAMPLE_MAX);
    send_element(SAMPLE_MIN);
    send_element('0);
    send_element('1);
  endtask

  task automatic test_truncation_toward_zero();
    configure(2, 2);
    // middle diagonal sums to -3 and then 5, both halves truncate toward zero
    send_element(SAMPLE_BITS'(7));
    send_element(SAMPLE_BITS'(-3));
    send_element('0);
    send_element(SAMPLE_MIN);
    send_element('1);
    send_element(SAMPLE_BITS'(5));
    send_element('0);
    send_element(SAMPLE_MAX);
  endtask

  task automatic test_full_scale_sums();
    // widest sums must still average back to the full-scale value
    configure(3, 3);
    repeat (9) send_element(SAMPLE_MIN);
  endtask

  task automatic test_zero_counts();
    // counts of zero behave as one
    configure(0, 0);
    send_element(SAMPLE_BITS'(-5));
    send_element(SAMPLE_BITS'(9));
  endtask

  task automatic test_ignored_index();
    // writes past the register list must not restart the matrix
    configure(3, 3);
    send_random_elements(4);
    settle_idle();
    write_register(REG_SPARE_FIRST, '1);
    write_register(REG_SPARE_LAST, '0);
    send_random_elements(5);
  endtask

  task automatic test_dropped_matrix();
    // a write in the middle of a matrix throws away the partial one
    configure(4, 3);
    send_random_elements(5);
    settle_idle();
    write_register(REG_ROW_COUNT, CFG_DATA_BITS'(4));
    send_random_elements(12);
  endtask

  task automatic test_size_extremes();
    // counts past the maximum clamp to it, a zero row count acts as one
    configure(127, 2);
    send_random_elements(active_rows() * active_columns());
    configure(0, 511);
    send_random_elements(active_rows() * active_columns());
  endtask

  task automatic test_random_matrices();
    int rows, columns, matrix_size, matrices, partial;
    while (random_elements < RANDOM_ELEMENTS) begin
      rows = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 127) : $urandom_range(0, 8);
      columns = (rows > 16) ? $urandom_range(0, 2) : $urandom_range(0, 12);
      settle_idle();
      // upper data bits are outside the row register and must be dropped
      if ($urandom_range(0, 3) != 0)
        write_register(REG_ROW_COUNT, {2'($urandom_range(0, 3)), 7'(rows)});
      write_register(REG_COLUMN_COUNT, CFG_DATA_BITS'(columns));
      sender_idling   = $urandom_range(0, 2) != 0;
      receiver_idling = $urandom_range(0, 2) != 0;
      matrix_size = active_rows() * active_columns();
      matrices = (matrix_size > 32) ? 1 : $urandom_range(1, 3);
      send_random_elements(matrices * matrix_size);
      random_elements += matrices * matrix_size;
      // sometimes leave a broken matrix for the next write to drop
      if (matrix_size > 1 && $urandom_range(0, 4) == 0) begin
        partial = $urandom_range(1, matrix_size - 1);
        send_random_elements(partial);
        random_elements += partial;
      end
    end
  endtask

  task automatic test_streaming_no_idle();
    sender_idling   = 1'b0;
    receiver_idling = 1'b0;
    configure(5, 7);
    send_random_elements(2 * 35);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_element_matrices();
    test_truncation_toward_zero();
    test_full_scale_sums();
    test_zero_counts();
    test_ignored_index();
    test_dropped_matrix();
    test_size_extremes();
    test_random_matrices();
    test_streaming_no_idle();
    settle_idle();
    $display("streamed %0d elements over %0d register writes, %0d means compared",
             elements_sent, register_writes, means_checked);
    $display("sizes from 1x1 to the clamped maxima, %0d mismatches", mismatches);
    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("hankel_diagonal_averager_unit_tb passed");
    end else begin
      $display("hankel_diagonal_averager_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d means outstanding", pending_means.size());
    $display("hankel_diagonal_averager_unit_tb failed");
    $finish;
  end

endmodule
